// ----- hdl/escape_time_spline_colouring_core_macros.svh -----
// assertion helpers for the escape-time colouring core
`ifndef ESCAPE_TIME_SPLINE_COLOURING_CORE_MACROS_SVH
`define ESCAPE_TIME_SPLINE_COLOURING_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ETSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etsc assertion failed");

// next-cycle implication
`define ETSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etsc assertion failed");

`endif

// ----- hdl/etsc_pkg.sv -----
package etsc_pkg;

  localparam int COEF_DEPTH_DEF = 64;
  localparam int COORD_FRAC_DEF = 58;
  localparam int COEF_FRAC_DEF  = 16;

  localparam int COUNT_W   = 16;
  localparam int ORIGIN_W  = 32;
  localparam int SPACING_W = 31;
  localparam int COORD_W   = 64;
  localparam int TAG_W     = 12;
  localparam int COEF_W    = 32;
  localparam int CHAN_W    = 2;
  localparam int SLOT_W    = 6;
  localparam int COLOUR_W  = 8;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  localparam int LIMIT_RESET        = 4000;
  localparam int SPACING_RESET      = 6554;
  localparam int COLOUR_MAX         = 255;
  localparam int ESCAPE_RADIUS_SQ   = 4;

  localparam logic [1:0] REG_LIMIT   = 2'd0;
  localparam logic [1:0] REG_ORIGIN  = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_COEF  = 1'b1;

  localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_STORE, ST_CHECK, ST_STEP, ST_COLOR, ST_DIVGO, ST_DIVW,
    ST_WSQ, ST_WCU, ST_WSUM, ST_RD, ST_OUT
  } etsc_state_t;

  typedef enum logic [1:0] {PS_XX, PS_YY, PS_XY} prod_sel_t;
  typedef enum logic [1:0] {DS_XQ, DS_MQ, DS_FQ} div_sel_t;

  typedef struct packed {
    logic      load_px;
    logic      load_coef;
    logic      mul_en;
    logic [1:0] pp_idx;
    logic      acc_clr;
    prod_sel_t psel;
    logic      store;
    logic      step;
    logic      div_start;
    logic      div_cap;
    div_sel_t  dsel;
    logic      wsq;
    logic      wcu;
    logic      wsum;
    logic      rd_en;
    logic [1:0] tap;
    logic      col_clr;
    logic      out_load;
  } etsc_cmd_t;

  typedef struct packed {
    logic mag_esc;
    logic lim_hit;
    logic count_nz;
    logic fits;
    logic div_done;
    logic out_free;
  } etsc_status_t;

endpackage

// ----- hdl/escape_time_spline_colouring_core.sv -----
// sequence: escape steps on the shared multiplier loop, each with a magnitude check,
// then colouring by three serial divides, skipped for in-set pixels
// throughput: one pixel at a time, set by the shared 32x32 multiplier loop and
// the bit-serial divider; a coefficient load is taken while idle and leaves it idle
// reset: synchronous, clears control and config; coefficient tables undefined
module escape_time_spline_colouring_core import etsc_pkg::*; #(
  parameter int COEF_DEPTH      = COEF_DEPTH_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [TAG_W-1:0]           pixel_col,
  input  logic [TAG_W-1:0]           pixel_row,
  input  logic signed [COORD_W-1:0]  real_coord,
  input  logic signed [COORD_W-1:0]  imag_coord,
  input  logic [CHAN_W-1:0]          coef_channel,
  input  logic [SLOT_W-1:0]          coef_slot,
  input  logic signed [COEF_W-1:0]   coef_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [TAG_W-1:0]           out_col,
  output logic [TAG_W-1:0]           out_row,
  output logic [COLOUR_W-1:0]        red,
  output logic [COLOUR_W-1:0]        green,
  output logic [COLOUR_W-1:0]        blue,
  output logic                       in_set,
  output logic [COUNT_W-1:0]         iterations
);

  logic [COUNT_W-1:0]         iteration_limit;
  logic signed [ORIGIN_W-1:0] knot_origin;
  logic [SPACING_W-1:0]       knot_spacing;
  logic                       cfg_wr;
  etsc_cmd_t                  cmd;
  etsc_status_t               status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= COUNT_W'(LIMIT_RESET);
      knot_origin     <= '0;
      knot_spacing    <= SPACING_W'(SPACING_RESET);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LIMIT:   iteration_limit <= pwdata[COUNT_W-1:0];
        REG_ORIGIN:  knot_origin     <= $signed(pwdata[ORIGIN_W-1:0]);
        REG_SPACING: knot_spacing    <= pwdata[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LIMIT:   prdata = APB_DW'(iteration_limit);
      REG_ORIGIN:  prdata = APB_DW'(knot_origin);
      REG_SPACING: prdata = APB_DW'(knot_spacing);
      default:     prdata = '0;
    endcase
  end

  etsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  etsc_dp #(
    .COEF_DEPTH      (COEF_DEPTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .pixel_col       (pixel_col),
    .pixel_row       (pixel_row),
    .real_coord      (real_coord),
    .imag_coord      (imag_coord),
    .coef_channel    (coef_channel),
    .coef_slot       (coef_slot),
    .coef_word       (coef_word),
    .iteration_limit (iteration_limit),
    .knot_origin     (knot_origin),
    .knot_spacing    (knot_spacing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_col         (out_col),
    .out_row         (out_row),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .in_set          (in_set),
    .iterations      (iterations)
  );

endmodule

// ----- hdl/etsc_div.sv -----
module etsc_div import etsc_pkg::*; #(
  parameter int NUMW = SPACING_W + COEF_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUMW-1:0]      num,
  input  logic [SPACING_W-1:0] den,
  output logic                 done,
  output logic [NUMW-1:0]      quo,
  output logic [SPACING_W-1:0] rem
);

  localparam int CW = $clog2(NUMW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [SPACING_W:0] r2;
  logic          sub_ok;

  // restoring division, one quotient bit a cycle
  assign r2     = {rem, quo[NUMW-1]};
  assign sub_ok = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NUMW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NUMW-2:0], sub_ok};
      rem <= sub_ok ? SPACING_W'(r2 - {1'b0, den}) : r2[SPACING_W-1:0];
    end
  end

endmodule

// ----- hdl/etsc_ctrl.sv -----
module etsc_ctrl import etsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         kind,
  input  etsc_status_t status,
  output logic         in_stall,
  output etsc_cmd_t    cmd
);

  etsc_state_t state, state_next;
  logic [2:0]  cnt, cnt_next;
  prod_sel_t   psel, psel_next;
  div_sel_t    dsel, dsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      psel  <= PS_XX;
      dsel  <= DS_XQ;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      psel  <= psel_next;
      dsel  <= dsel_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    psel_next  = psel;
    dsel_next  = dsel;
    cmd        = '0;
    cmd.psel   = psel;
    cmd.dsel   = dsel;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (kind == KIND_COEF) begin
            cmd.load_coef = 1'b1;
          end else begin
            cmd.load_px = 1'b1;
            psel_next   = PS_XX;
            cnt_next    = '0;
            state_next  = ST_MUL;
          end
        end
      end
      // four 32x32 partial products, each accumulated in the cycle after it is formed
      ST_MUL: begin
        cmd.mul_en  = (cnt < 3'd4);
        cmd.pp_idx  = cnt[1:0];
        cmd.acc_clr = (cnt == 3'd0);
        if (cnt == 3'd4) begin
          cnt_next   = '0;
          state_next = ST_STORE;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        case (psel)
          PS_XX: begin
            psel_next  = PS_YY;
            state_next = ST_MUL;
          end
          PS_YY:   state_next = ST_CHECK;
          default: state_next = ST_STEP;
        endcase
      end
      ST_CHECK: begin
        if (status.lim_hit || (status.count_nz && status.mag_esc)) begin
          state_next = ST_COLOR;
        end else begin
          psel_next  = PS_XY;
          state_next = ST_MUL;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (!status.fits) begin
          state_next = ST_COLOR;
        end else begin
          psel_next  = PS_XX;
          state_next = ST_MUL;
        end
      end
      ST_COLOR: begin
        dsel_next  = DS_XQ;
        state_next = status.lim_hit ? ST_OUT : ST_DIVGO;
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVW;
      end
      ST_DIVW: begin
        cmd.div_cap = status.div_done;
        if (status.div_done) begin
          case (dsel)
            DS_XQ: begin
              dsel_next  = DS_MQ;
              state_next = ST_DIVGO;
            end
            DS_MQ: begin
              dsel_next  = DS_FQ;
              state_next = ST_DIVGO;
            end
            default: state_next = ST_WSQ;
          endcase
        end
      end
      ST_WSQ: begin
        cmd.wsq    = 1'b1;
        state_next = ST_WCU;
      end
      ST_WCU: begin
        cmd.wcu    = 1'b1;
        state_next = ST_WSUM;
      end
      ST_WSUM: begin
        cmd.wsum   = 1'b1;
        cnt_next   = '0;
        state_next = ST_RD;
      end
      // read, multiply, accumulate over the four spline taps
      ST_RD: begin
        cmd.rd_en   = (cnt < 3'd4);
        cmd.tap     = cnt[1:0];
        cmd.col_clr = (cnt == 3'd0);
        if (cnt == 3'd5) begin
          cnt_next   = '0;
          state_next = ST_OUT;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/etsc_dp.sv -----
module etsc_dp import etsc_pkg::*; #(
  parameter int COEF_DEPTH      = COEF_DEPTH_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  etsc_cmd_t                   cmd,
  output etsc_status_t                status,
  input  logic [TAG_W-1:0]            pixel_col,
  input  logic [TAG_W-1:0]            pixel_row,
  input  logic signed [COORD_W-1:0]   real_coord,
  input  logic signed [COORD_W-1:0]   imag_coord,
  input  logic [CHAN_W-1:0]           coef_channel,
  input  logic [SLOT_W-1:0]           coef_slot,
  input  logic signed [COEF_W-1:0]    coef_word,
  input  logic [COUNT_W-1:0]          iteration_limit,
  input  logic signed [ORIGIN_W-1:0]  knot_origin,
  input  logic [SPACING_W-1:0]        knot_spacing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [TAG_W-1:0]            out_col,
  output logic [TAG_W-1:0]            out_row,
  output logic [COLOUR_W-1:0]         red,
  output logic [COLOUR_W-1:0]         green,
  output logic [COLOUR_W-1:0]         blue,
  output logic                        in_set,
  output logic [COUNT_W-1:0]          iterations
);

  localparam int AW   = $clog2(COEF_DEPTH);
  localparam int F    = COORD_FRAC_BITS;
  localparam int Q    = COEF_FRAC_BITS;
  localparam int NUMW = SPACING_W + Q;
  localparam int WW   = Q + 3;
  localparam int SW   = Q + 5;
  localparam int PW   = Q + 36;
  localparam int ACW  = Q + 38;
  localparam int MW   = 36;
  localparam int TW   = 34;
  localparam int XW   = 2 * COORD_W;
  localparam logic signed [XW-1:0] ESC_LIM = XW'(ESCAPE_RADIUS_SQ) <<< F;

  // ---------------- escape iteration ----------------
  logic signed [COORD_W-1:0] cx, cy, zx, zy;
  logic [TAG_W-1:0]          col_tag, row_tag;
  logic [COUNT_W-1:0]        count;
  logic [COORD_W-1:0]        ax, ay, opa, opb;
  logic [31:0]               ha, hb;
  logic [63:0]               pp;
  logic [1:0]                pp_sh;
  logic                      pp_vld;
  logic [XW-1:0]             acc, pp_ext;
  logic signed [XW-1:0]      pval, xx, yy, xy, nx, ny;
  logic                      pneg;

  assign ax  = zx[COORD_W-1] ? (~zx + COORD_W'(1)) : zx;
  assign ay  = zy[COORD_W-1] ? (~zy + COORD_W'(1)) : zy;
  assign opa = (cmd.psel == PS_YY) ? ay : ax;
  assign opb = (cmd.psel == PS_XX) ? ax : ay;
  assign ha  = cmd.pp_idx[1] ? opa[63:32] : opa[31:0];
  assign hb  = cmd.pp_idx[0] ? opb[63:32] : opb[31:0];

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      default: pp_ext = {pp, 64'd0};
    endcase
  end

  assign pneg = (cmd.psel == PS_XY) && (zx[COORD_W-1] ^ zy[COORD_W-1]);
  assign pval = pneg ? $signed(~acc + XW'(1)) : $signed(acc);
  assign nx   = xx - yy + XW'(cx);
  assign ny   = xy + XW'(cy);

  always_ff @(posedge clk) begin
    if (rst) pp_vld <= 1'b0;
    else     pp_vld <= cmd.mul_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      pp    <= 64'(ha) * 64'(hb);
      pp_sh <= {1'b0, cmd.pp_idx[1]} + {1'b0, cmd.pp_idx[0]};
    end
    if (cmd.acc_clr)     acc <= '0;
    else if (pp_vld)     acc <= acc + pp_ext;
    if (cmd.store) begin
      case (cmd.psel)
        PS_XX:   xx <= pval >>> F;
        PS_YY:   yy <= pval >>> F;
        default: xy <= pval >>> (F - 1);
      endcase
    end
    if (cmd.load_px) begin
      cx      <= real_coord;
      cy      <= imag_coord;
      zx      <= real_coord;
      zy      <= imag_coord;
      count   <= '0;
      col_tag <= pixel_col;
      row_tag <= pixel_row;
    end else if (cmd.step) begin
      count <= count + COUNT_W'(1);
      if (status.fits) begin
        zx <= nx[COORD_W-1:0];
        zy <= ny[COORD_W-1:0];
      end
    end
  end

  // ---------------- spline position ----------------
  logic [SPACING_W-1:0] h, den;
  logic [NUMW-1:0]      num, quo;
  logic [SPACING_W-1:0] drem, rem_r;
  logic                 div_done;
  logic [Q-1:0]         xq;
  logic signed [TW-1:0] tval;
  logic [TW-2:0]        tabs;
  logic                 tneg;
  logic signed [MW-1:0] mq, m;
  logic [Q-1:0]         f, sqf, cuf;
  logic [Q:0]           g, sqg, cug;
  logic [WW-1:0]        w [4];
  logic [SW-1:0]        w1s, w2s;

  assign h = (knot_spacing == '0) ? SPACING_W'(1) : knot_spacing;

  always_comb begin
    case (cmd.dsel)
      DS_XQ: begin
        den = SPACING_W'(iteration_limit);
        num = NUMW'(count) << Q;
      end
      DS_MQ: begin
        den = h;
        num = NUMW'(tabs);
      end
      default: begin
        den = h;
        num = NUMW'(rem_r) << Q;
      end
    endcase
  end

  etsc_div #(.NUMW(NUMW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo),
    .rem   (drem)
  );

  assign xq   = quo[Q-1:0];
  assign tval = $signed(TW'(xq)) - TW'(knot_origin);
  assign mq   = $signed(quo[MW-1:0]);

  assign w1s = (SW'(1) << Q) + SW'(g) * SW'(3) + SW'(sqg) * SW'(3) - SW'(cug) * SW'(3);
  assign w2s = (SW'(1) << Q) + SW'(f) * SW'(3) + SW'(sqf) * SW'(3) - SW'(cuf) * SW'(3);

  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.dsel)
        DS_XQ: begin
          tneg <= tval[TW-1];
          tabs <= tval[TW-1] ? (TW-1)'(-tval) : (TW-1)'(tval);
        end
        DS_MQ: begin
          if (!tneg) begin
            m     <= mq;
            rem_r <= drem;
          end else if (drem != '0) begin
            m     <= -mq - MW'(1);
            rem_r <= h - drem;
          end else begin
            m     <= -mq;
            rem_r <= '0;
          end
        end
        default: begin
          f <= quo[Q-1:0];
          g <= ((Q+1)'(1) << Q) - (Q+1)'(quo[Q-1:0]);
        end
      endcase
    end
    if (cmd.wsq) begin
      sqf <= Q'((2*Q)'(f) * (2*Q)'(f) >> Q);
      sqg <= (Q+1)'((2*Q+2)'(g) * (2*Q+2)'(g) >> Q);
    end
    if (cmd.wcu) begin
      cuf <= Q'((2*Q)'(sqf) * (2*Q)'(f) >> Q);
      cug <= (Q+1)'((2*Q+2)'(sqg) * (2*Q+2)'(g) >> Q);
    end
    if (cmd.wsum) begin
      w[0] <= WW'(cug);
      w[1] <= WW'(w1s);
      w[2] <= WW'(w2s);
      w[3] <= WW'(cuf);
    end
  end

  // ---------------- coefficient tables and colour sums ----------------
  logic [COEF_W-1:0] mem_r [COEF_DEPTH];
  logic [COEF_W-1:0] mem_g [COEF_DEPTH];
  logic [COEF_W-1:0] mem_b [COEF_DEPTH];
  logic [31:0]       slot_x;
  logic              wr_ok;
  logic [AW-1:0]     waddr, raddr;
  logic signed [MW-1:0] idx;
  logic              rd_ok_c, rd_ok, rd_vld, prod_ok, prod_vld;
  logic [1:0]        rd_tap;
  logic [COEF_W-1:0] rd_r, rd_g, rd_b;
  logic signed [PW-1:0]  prod_r, prod_g, prod_b, wsel;
  logic signed [ACW-1:0] acc_r, acc_g, acc_b;

  assign slot_x  = 32'(coef_slot);
  assign wr_ok   = cmd.load_coef && (slot_x < 32'(COEF_DEPTH));
  assign waddr   = slot_x[AW-1:0];
  assign idx     = m - MW'(1) + $signed(MW'(cmd.tap));
  assign rd_ok_c = !idx[MW-1] && (idx[MW-2:0] < (MW-1)'(COEF_DEPTH));
  assign raddr   = idx[AW-1:0];
  assign wsel    = PW'($signed({1'b0, w[rd_tap]}));

  always_ff @(posedge clk) begin
    if (wr_ok && coef_channel == CH_RED) mem_r[waddr] <= coef_word;
    if (cmd.rd_en)                       rd_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_ok && coef_channel == CH_GREEN) mem_g[waddr] <= coef_word;
    if (cmd.rd_en)                         rd_g <= mem_g[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_ok && coef_channel == CH_BLUE) mem_b[waddr] <= coef_word;
    if (cmd.rd_en)                        rd_b <= mem_b[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.rd_en;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ok  <= rd_ok_c;
      rd_tap <= cmd.tap;
    end
    if (rd_vld) begin
      prod_r  <= PW'($signed(rd_r)) * wsel;
      prod_g  <= PW'($signed(rd_g)) * wsel;
      prod_b  <= PW'($signed(rd_b)) * wsel;
      prod_ok <= rd_ok;
    end
    if (cmd.col_clr) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (prod_vld && prod_ok) begin
      acc_r <= acc_r + ACW'(prod_r);
      acc_g <= acc_g + ACW'(prod_g);
      acc_b <= acc_b + ACW'(prod_b);
    end
  end

  function automatic logic [COLOUR_W-1:0] clamp(input logic signed [ACW-1:0] a);
    logic signed [ACW-1:0] v;
    v = a >>> (2 * Q);
    if (a < 0)                                 return '0;
    else if (v > $signed(ACW'(COLOUR_MAX)))    return COLOUR_W'(COLOUR_MAX);
    else                                       return v[COLOUR_W-1:0];
  endfunction

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst)                          out_valid <= 1'b0;
    else if (cmd.out_load)            out_valid <= 1'b1;
    else if (out_valid && !out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col    <= col_tag;
      out_row    <= row_tag;
      in_set     <= status.lim_hit;
      iterations <= count;
      red        <= status.lim_hit ? '0 : clamp(acc_r);
      green      <= status.lim_hit ? '0 : clamp(acc_g);
      blue       <= status.lim_hit ? '0 : clamp(acc_b);
    end
  end

  assign status.mag_esc  = (xx + yy) >= ESC_LIM;
  assign status.lim_hit  = count >= iteration_limit;
  assign status.count_nz = count != '0;
  assign status.fits     = (nx[XW-1:COORD_W-1] == {(COORD_W+1){nx[COORD_W-1]}}) &&
                           (ny[XW-1:COORD_W-1] == {(COORD_W+1){ny[COORD_W-1]}});
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ----- hdl/etsc_chk.sv -----
`include "escape_time_spline_colouring_core_macros.svh"

module etsc_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_col,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic        in_set,
  input logic [15:0] iterations
);

  // a held result keeps its payload
  `ETSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_col) && $stable(red) && $stable(iterations))
  // in-set pixels are black
  `ETSC_ASSERT_NOW(a_black, out_valid && in_set, red == 8'd0 && green == 8'd0 && blue == 8'd0)
  // an escaped pixel took at least one step
  `ETSC_ASSERT_NOW(a_escape_steps, out_valid && !in_set, iterations != 16'd0)
  // a pixel item keeps the block busy on the next cycle
  `ETSC_ASSERT_NEXT(a_busy, in_valid && !in_stall && !kind, in_stall)

endmodule

bind escape_time_spline_colouring_core etsc_chk u_chk (.*);

// ----- tb/tb_escape_time_spline_colouring_core.sv -----
`default_nettype none

module tb_escape_time_spline_colouring_core;
  import etsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F = COORD_FRAC_DEF;
  localparam int Q = COEF_FRAC_DEF;
  localparam int STALL_LIMIT = 200000;
  localparam int CAL_SLOTS = 16;

  typedef struct {
    logic [TAG_W-1:0]    col;
    logic [TAG_W-1:0]    row;
    logic [COLOUR_W-1:0] r;
    logic [COLOUR_W-1:0] g;
    logic [COLOUR_W-1:0] b;
    logic                ins;
    logic [COUNT_W-1:0]  n;
  } pixel_result_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic kind;
  logic [TAG_W-1:0] pixel_col, pixel_row, out_col, out_row;
  logic signed [COORD_W-1:0] real_coord, imag_coord;
  logic [CHAN_W-1:0] coef_channel;
  logic [SLOT_W-1:0] coef_slot;
  logic signed [COEF_W-1:0] coef_word;
  logic [COLOUR_W-1:0] red, green, blue;
  logic in_set;
  logic [COUNT_W-1:0] iterations;

  escape_time_spline_colouring_core dut (.*);

  // predictor state
  logic signed [COEF_W-1:0]  coef_tab [3][COEF_DEPTH_DEF];
  logic [COUNT_W-1:0]        limit_q;
  logic signed [ORIGIN_W-1:0] origin_q;
  logic [SPACING_W-1:0]      spacing_q;

  pixel_result_t pending_pixels[$];
  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid <= 1'b0; kind <= KIND_PIXEL; pixel_col <= '0; pixel_row <= '0;
    real_coord <= '0; imag_coord <= '0; coef_channel <= CH_RED; coef_slot <= '0;
    coef_word <= '0; out_stall <= 1'b0;
  end

  function automatic longint sq_q(longint a);
    return (a * a) >>> Q;
  endfunction

  function automatic longint cu_q(longint a);
    return (sq_q(a) * a) >>> Q;
  endfunction

  function automatic bit fits64(logic signed [127:0] v);
    return (&v[127:63]) || !(|v[127:63]);
  endfunction

  function automatic int unsigned escape_count(logic signed [63:0] cx, logic signed [63:0] cy);
    logic signed [127:0] zx, zy, nx, ny, mag, four;
    int unsigned n;
    bit esc;
    n = 0;
    esc = 0;
    four = 128'sd4 <<< F;
    zx = cx;
    zy = cy;
    while (n < limit_q && !esc) begin
      nx = ((zx * zx) >>> F) - ((zy * zy) >>> F) + cx;
      ny = ((zx * zy) >>> (F - 1)) + cy;
      n++;
      if (!fits64(nx) || !fits64(ny)) begin
        esc = 1;
      end else begin
        zx = $signed(nx[63:0]);
        zy = $signed(ny[63:0]);
        mag = ((zx * zx) >>> F) + ((zy * zy) >>> F);
        if (mag >= four) esc = 1;
      end
    end
    return n;
  endfunction

  function automatic logic [COLOUR_W-1:0] spline_level(int ch, longint xq);
    longint h, t, m, rem, f, g, acc, v, idx;
    longint w[4];
    h = (spacing_q == 0) ? 1 : longint'(spacing_q);
    t = xq - longint'(origin_q);
    m = t / h;
    rem = t % h;
    if (rem < 0) begin
      m--;
      rem += h;
    end
    f = (rem <<< Q) / h;
    g = (longint'(1) <<< Q) - f;
    w[0] = cu_q(g);
    w[1] = (longint'(1) <<< Q) + 3 * g + 3 * sq_q(g) - 3 * cu_q(g);
    w[2] = (longint'(1) <<< Q) + 3 * f + 3 * sq_q(f) - 3 * cu_q(f);
    w[3] = cu_q(f);
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      idx = m - 1 + i;
      if (idx >= 0 && idx < COEF_DEPTH_DEF) acc += longint'(coef_tab[ch][idx]) * w[i];
    end
    if (acc < 0) return '0;
    v = acc >>> (2 * Q);
    return (v > COLOUR_MAX) ? COLOUR_W'(COLOUR_MAX) : COLOUR_W'(v);
  endfunction

  function automatic pixel_result_t predict_pixel(logic [TAG_W-1:0] col, logic [TAG_W-1:0] row,
                                                  logic signed [63:0] cx, logic signed [63:0] cy);
    pixel_result_t res;
    int unsigned n;
    longint xq;
    n = escape_count(cx, cy);
    res.col = col;
    res.row = row;
    res.ins = (n >= limit_q);
    res.n = COUNT_W'(n);
    res.r = '0;
    res.g = '0;
    res.b = '0;
    if (!res.ins) begin
      xq = (longint'(n) <<< Q) / longint'(limit_q);
      res.r = spline_level(CH_RED, xq);
      res.g = spline_level(CH_GREEN, xq);
      res.b = spline_level(CH_BLUE, xq);
    end
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("mismatch: result with no pixel outstanding (col %0d row %0d)",
                 out_col, out_row);
        mismatch_count++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_col !== e.col) report("out_col", out_col, e.col);
        if (out_row !== e.row) report("out_row", out_row, e.row);
        if (red !== e.r) report("red", red, e.r);
        if (green !== e.g) report("green", green, e.g);
        if (blue !== e.b) report("blue", blue, e.b);
        if (in_set !== e.ins) report("in_set", in_set, e.ins);
        if (iterations !== e.n) report("iterations", iterations, e.n);
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_item(logic k, logic [TAG_W-1:0] col, logic [TAG_W-1:0] row,
                           logic [63:0] rc, logic [63:0] ic, logic [CHAN_W-1:0] ch,
                           logic [SLOT_W-1:0] slot, logic [COEF_W-1:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    pixel_col <= col;
    pixel_row <= row;
    real_coord <= rc;
    imag_coord <= ic;
    coef_channel <= ch;
    coef_slot <= slot;
    coef_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == KIND_COEF) begin
      if (ch != 2'd3) coef_tab[ch][slot] = word;
    end else begin
      pending_pixels.push_back(predict_pixel(col, row, rc, ic));
    end
  endtask

  task automatic send_pixel(logic [TAG_W-1:0] col, logic [TAG_W-1:0] row,
                            logic [63:0] rc, logic [63:0] ic);
    send_item(KIND_PIXEL, col, row, rc, ic, CH_RED, SLOT_W'($urandom), $urandom);
  endtask

  task automatic send_coef(logic [CHAN_W-1:0] ch, logic [SLOT_W-1:0] slot, logic [31:0] word);
    send_item(KIND_COEF, TAG_W'($urandom), TAG_W'($urandom), {$urandom, $urandom},
              {$urandom, $urandom}, ch, slot, word);
  endtask

  function automatic logic [63:0] fx(real v);
    return 64'(longint'(v * (2.0 ** F)));
  endfunction

  function automatic logic [31:0] colour_word();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 320 << Q)) - 32'(20 << Q);
  endfunction

  function automatic logic [63:0] random_point();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return 64'($signed({$urandom, $urandom}) >>> 4);
  endfunction

  // wait until all pixels are out, then let a trailing load settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LIMIT:   limit_q = val[COUNT_W-1:0];
      REG_ORIGIN:  origin_q = val;
      REG_SPACING: spacing_q = val[SPACING_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_spline(logic [31:0] org, logic [31:0] sp);
    apb_write(REG_ORIGIN, org);
    apb_write(REG_SPACING, sp);
  endtask

  // fills the low CAL_SLOTS slots of each channel; some knot settings below reach past them
  task automatic load_tables();
    for (int c = 0; c < 3; c++)
      for (int s = 0; s < CAL_SLOTS; s++) send_coef(CHAN_W'(c), SLOT_W'(s), colour_word());
    drain();
  endtask

  task automatic test_directed();
    apb_write(REG_LIMIT, 32);
    send_pixel(0, 0, fx(0.0), fx(0.0));
    send_pixel(12'hfff, 12'hfff, fx(-1.0), fx(0.0));
    send_pixel(1, 2, fx(2.0), fx(2.0));
    send_pixel(3, 4, fx(-2.0), fx(0.0));
    send_pixel(5, 6, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
    send_pixel(7, 8, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    send_pixel(9, 10, fx(0.3), fx(0.5));
    send_pixel(11, 12, fx(-0.75), fx(0.11));
    send_pixel(13, 14, fx(0.26), fx(0.0));
    // channel 3 load must be dropped
    send_coef(2'd3, 6'd5, 32'h7fff_ffff);
    send_coef(CH_BLUE, 6'd63, 32'h8000_0000);
    send_coef(CH_GREEN, 6'd0, 32'(100 << Q));
    send_pixel(15, 16, fx(0.4), fx(-0.3));
    drain();
    // escape on the last allowed step still counts as in set
    apb_write(REG_LIMIT, 1);
    send_pixel(17, 18, fx(1.0), fx(1.0));
    drain();
  endtask

  task automatic test_limit_extremes();
    apb_write(REG_LIMIT, 0);
    send_pixel(20, 21, fx(2.0), fx(2.0));
    send_pixel(22, 23, fx(0.0), fx(0.0));
    drain();
    apb_write(REG_LIMIT, 65535);
    send_pixel(24, 25, fx(2.0), fx(2.0));
    send_pixel(26, 27, 64'h7fff_ffff_ffff_ffff, 64'h0);
    drain();
  endtask

  task automatic test_spline_settings();
    logic [31:0] orgs[6] = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'(-3000), 32'(5000), 32'h0};
    logic [31:0] sps[6] = '{32'h0, 32'h7fff_ffff, 32'd1, 32'd6000, 32'd9000, 32'd6554};
    apb_write(REG_LIMIT, 16);
    foreach (orgs[i]) begin
      set_spline(orgs[i], sps[i]);
      repeat (3) send_pixel(TAG_W'($urandom), TAG_W'($urandom), random_point(), random_point());
      drain();
    end
  endtask

  task automatic test_random(int items);
    apb_write(REG_LIMIT, 40);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) begin
        // sender holds off until the block has emptied
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 4) == 0)
        send_coef(CHAN_W'($urandom), SLOT_W'($urandom), colour_word());
      else
        send_pixel(TAG_W'($urandom), TAG_W'($urandom), random_point(), random_point());
    end
    drain();
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    out_stall <= 1'b0;
    set_spline(32'(-2000), 32'd8000);
    apb_write(REG_LIMIT, 24);
    for (int i = 0; i < 20; i++)
      send_pixel(TAG_W'($urandom), TAG_W'($urandom), random_point(), random_point());
    in_valid <= 1'b0;
  endtask

  initial begin
    limit_q = COUNT_W'(LIMIT_RESET);
    origin_q = '0;
    spacing_q = SPACING_W'(SPACING_RESET);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tables();
    test_directed();
    test_limit_extremes();
    test_spline_settings();
    set_spline(32'h0, 32'd6554);
    test_random(45);
    test_no_idle();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
